@@ rtl/hsbrgb_pkg.sv @@
// ----------------------------------------------------------------------------
// hsbrgb_pkg
// Shared constants for the HSB to RGB converter: channel widths, the fixed
// point unit value, color mode codes and hue sector codes.
// ----------------------------------------------------------------------------
package hsbrgb_pkg;

    localparam int FRAC_BITS = 12;
    localparam int CHAN_W    = FRAC_BITS + 1;
    // Hue times six fits in three more bits than a fraction.
    localparam int HP_W      = FRAC_BITS + 3;
    localparam int PROD_W    = 2 * CHAN_W;
    localparam int SECT_W    = HP_W - FRAC_BITS;

    localparam logic [CHAN_W-1:0] ONE = CHAN_W'(1) << FRAC_BITS;

    localparam logic MODE_RGB = 1'b0;
    localparam logic MODE_HSB = 1'b1;

    localparam logic [SECT_W-1:0] SECT_RED_YEL  = SECT_W'(0);
    localparam logic [SECT_W-1:0] SECT_YEL_GRN  = SECT_W'(1);
    localparam logic [SECT_W-1:0] SECT_GRN_CYN  = SECT_W'(2);
    localparam logic [SECT_W-1:0] SECT_CYN_BLU  = SECT_W'(3);
    localparam logic [SECT_W-1:0] SECT_BLU_MAG  = SECT_W'(4);

    function automatic logic [CHAN_W-1:0] sat_one(input logic [CHAN_W-1:0] v);
        sat_one = (v > ONE) ? ONE : v;
    endfunction

endpackage

@@ rtl/hsb_to_rgb_converter_unit.sv @@
// ----------------------------------------------------------------------------
// hsb_to_rgb_converter_unit
// Per-pixel color conversion from hue/saturation/brightness to RGB, with an
// RGB pass-through mode, in a three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
// A pixel beat enters on item_valid/item_stall with four 13-bit channels that
// carry 12 fraction bits each. The result beat leaves on
// result_valid/result_stall as red, green, blue and alpha. A beat is taken at
// a rising edge where valid is high and stall is low.
// color_mode is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is
// always high. Mode 0 passes the channels through, mode 1 converts HSB.
// Write the mode only while no beat is in flight.
// One beat per cycle is sustained while the result is not stalled: stage one
// saturates, multiplies brightness by saturation and scales hue, stage two
// forms the secondary component with the second multiplier, stage three
// places the components by sector into the output register. Empty stages are
// filled even while the result is stalled, so a stall holds the output and
// backs up into item_stall only when every stage is full. Reset empties the
// pipeline and sets the mode to pass-through.
// ----------------------------------------------------------------------------
module hsb_to_rgb_converter_unit
(
    input  logic                           clk,
    input  logic                           rst_n,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,

    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [hsbrgb_pkg::CHAN_W-1:0]  chan_a,
    input  logic [hsbrgb_pkg::CHAN_W-1:0]  chan_b,
    input  logic [hsbrgb_pkg::CHAN_W-1:0]  chan_c,
    input  logic [hsbrgb_pkg::CHAN_W-1:0]  chan_d,

    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [hsbrgb_pkg::CHAN_W-1:0]  red,
    output logic [hsbrgb_pkg::CHAN_W-1:0]  green,
    output logic [hsbrgb_pkg::CHAN_W-1:0]  blue,
    output logic [hsbrgb_pkg::CHAN_W-1:0]  alpha
);

    localparam int CW = hsbrgb_pkg::CHAN_W;
    localparam int FB = hsbrgb_pkg::FRAC_BITS;
    localparam int HW = hsbrgb_pkg::HP_W;
    localparam int PW = hsbrgb_pkg::PROD_W;
    localparam int SW = hsbrgb_pkg::SECT_W;

    logic mode_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;

    // Stage one registers.
    logic          s1_mode_reg;
    logic [CW-1:0] s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;
    logic [CW-1:0] s1_chroma_reg, s1_bri_reg;
    logic [HW-1:0] s1_hp_reg;

    // Stage two registers.
    logic          s2_mode_reg;
    logic [CW-1:0] s2_a_reg, s2_b_reg, s2_c_reg, s2_d_reg;
    logic [CW-1:0] s2_chroma_reg, s2_second_reg, s2_offset_reg;
    logic [SW-1:0] s2_sector_reg;

    // Output registers.
    logic [CW-1:0] red_reg, green_reg, blue_reg, alpha_reg;

    logic [CW-1:0] hue_s, sat_s, bri_s;
    logic [PW-1:0] chroma_prod;
    logic [HW-1:0] hp_next;

    logic [CW-1:0] frac2, hue_dist, ramp;
    logic [PW-1:0] second_prod;
    logic [HW-1:0] hp_dec;
    logic [SW-1:0] sector_next;

    logic [CW-1:0] r1, g1, b1;
    logic [CW-1:0] red_next, green_next, blue_next;

    // Each stage moves when it is empty or the stage after it moves.
    assign adv3       = !v3_reg || !result_stall;
    assign adv2       = !v2_reg || adv3;
    assign adv1       = !v1_reg || adv2;
    assign item_stall = !adv1;
    assign cfg_ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= hsbrgb_pkg::MODE_RGB;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (adv1)
            begin
                v1_reg <= item_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage one: saturate, chroma product, hue times six.
    always_comb
    begin
        hue_s       = hsbrgb_pkg::sat_one(chan_a);
        sat_s       = hsbrgb_pkg::sat_one(chan_b);
        bri_s       = hsbrgb_pkg::sat_one(chan_c);
        chroma_prod = PW'(bri_s) * PW'(sat_s);
        hp_next     = HW'({hue_s, 2'b00}) + HW'({hue_s, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && item_valid)
        begin
            s1_mode_reg   <= mode_reg;
            s1_a_reg      <= chan_a;
            s1_b_reg      <= chan_b;
            s1_c_reg      <= chan_c;
            s1_d_reg      <= chan_d;
            s1_chroma_reg <= chroma_prod[FB +: CW];
            s1_bri_reg    <= bri_s;
            s1_hp_reg     <= hp_next;
        end
    end

    // Stage two: secondary component, sector and offset.
    always_comb
    begin
        frac2       = s1_hp_reg[CW-1:0];
        hue_dist    = (frac2 >= hsbrgb_pkg::ONE) ? (frac2 - hsbrgb_pkg::ONE)
                                                 : (hsbrgb_pkg::ONE - frac2);
        ramp        = hsbrgb_pkg::ONE - hue_dist;
        second_prod = PW'(s1_chroma_reg) * PW'(ramp);
        hp_dec      = s1_hp_reg - HW'(1);
        // A hue landing exactly on a boundary belongs to the lower sector.
        sector_next = (s1_hp_reg == '0) ? hsbrgb_pkg::SECT_RED_YEL : hp_dec[HW-1:FB];
    end

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_a_reg      <= s1_a_reg;
            s2_b_reg      <= s1_b_reg;
            s2_c_reg      <= s1_c_reg;
            s2_d_reg      <= s1_d_reg;
            s2_chroma_reg <= s1_chroma_reg;
            s2_second_reg <= second_prod[FB +: CW];
            s2_offset_reg <= s1_bri_reg - s1_chroma_reg;
            s2_sector_reg <= sector_next;
        end
    end

    // Stage three: place chroma and secondary by sector, add the offset.
    always_comb
    begin
        r1 = '0;
        g1 = '0;
        b1 = '0;
        unique case (s2_sector_reg)
            hsbrgb_pkg::SECT_RED_YEL:
            begin
                r1 = s2_chroma_reg;
                g1 = s2_second_reg;
            end
            hsbrgb_pkg::SECT_YEL_GRN:
            begin
                r1 = s2_second_reg;
                g1 = s2_chroma_reg;
            end
            hsbrgb_pkg::SECT_GRN_CYN:
            begin
                g1 = s2_chroma_reg;
                b1 = s2_second_reg;
            end
            hsbrgb_pkg::SECT_CYN_BLU:
            begin
                g1 = s2_second_reg;
                b1 = s2_chroma_reg;
            end
            hsbrgb_pkg::SECT_BLU_MAG:
            begin
                r1 = s2_second_reg;
                b1 = s2_chroma_reg;
            end
            default:
            begin
                r1 = s2_chroma_reg;
                b1 = s2_second_reg;
            end
        endcase

        if (s2_mode_reg == hsbrgb_pkg::MODE_HSB)
        begin
            red_next   = r1 + s2_offset_reg;
            green_next = g1 + s2_offset_reg;
            blue_next  = b1 + s2_offset_reg;
        end
        else
        begin
            red_next   = s2_a_reg;
            green_next = s2_b_reg;
            blue_next  = s2_c_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv3 && v2_reg)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            alpha_reg <= s2_d_reg;
        end
    end

    assign result_valid = v3_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;

endmodule

@@ verif/pixel_result_check.sv @@
// ----------------------------------------------------------------------------
// pixel_result_check
// Watches the mode write, pixel and result channels of the HSB to RGB
// converter. It predicts each result pixel from the accepted input pixel and
// the current color mode, and compares every field with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_result_check
    import hsbrgb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic              cfg_data,

    input  logic              item_valid,
    input  logic              item_stall,
    input  logic [CHAN_W-1:0] chan_a,
    input  logic [CHAN_W-1:0] chan_b,
    input  logic [CHAN_W-1:0] chan_c,
    input  logic [CHAN_W-1:0] chan_d,

    input  logic              result_valid,
    input  logic              result_stall,
    input  logic [CHAN_W-1:0] red,
    input  logic [CHAN_W-1:0] green,
    input  logic [CHAN_W-1:0] blue,
    input  logic [CHAN_W-1:0] alpha,

    output int                error_count,
    output int                pending
);

    localparam int HUE_SECTORS = 6;
    localparam int MAX_PRINTS  = 60;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } rgba_t;

    rgba_t expected_rgba[$];
    logic  mode_copy;
    int    fail_total;
    int    beat_count;

    assign error_count = fail_total;

    function automatic logic [CHAN_W-1:0] clamp_unit(input logic [CHAN_W-1:0] v);
        return (v > ONE) ? ONE : v;
    endfunction

    // Fixed point HSB to RGB with truncating products; boundaries of hue
    // sectors belong to the lower sector.
    function automatic rgba_t predict_rgba(input logic mode,
                                           input logic [CHAN_W-1:0] a,
                                           input logic [CHAN_W-1:0] b,
                                           input logic [CHAN_W-1:0] c,
                                           input logic [CHAN_W-1:0] d);
        logic [CHAN_W-1:0] hue;
        logic [CHAN_W-1:0] sat;
        logic [CHAN_W-1:0] bri;
        logic [CHAN_W-1:0] chroma;
        logic [CHAN_W-1:0] second;
        logic [CHAN_W-1:0] offset;
        logic [CHAN_W-1:0] wrapped;
        logic [CHAN_W-1:0] hue_dist;
        logic [CHAN_W-1:0] r1;
        logic [CHAN_W-1:0] g1;
        logic [CHAN_W-1:0] b1;
        logic [PROD_W-1:0] prod;
        logic [HP_W-1:0]   hp;
        logic [SECT_W-1:0] sector;
        rgba_t             res;

        res.alpha = d;
        if (mode != MODE_HSB)
        begin
            res.red   = a;
            res.green = b;
            res.blue  = c;
            return res;
        end

        hue = clamp_unit(a);
        sat = clamp_unit(b);
        bri = clamp_unit(c);

        prod   = PROD_W'(bri) * PROD_W'(sat);
        chroma = CHAN_W'(prod >> FRAC_BITS);
        hp     = HP_W'(hue) * HP_W'(HUE_SECTORS);

        // The low FRAC_BITS+1 bits of the scaled hue are its value modulo two.
        wrapped  = hp[FRAC_BITS:0];
        hue_dist = (wrapped >= ONE) ? wrapped - ONE : ONE - wrapped;
        prod     = PROD_W'(chroma) * PROD_W'(ONE - hue_dist);
        second   = CHAN_W'(prod >> FRAC_BITS);

        sector = (hp == '0) ? SECT_RED_YEL : SECT_W'((hp - HP_W'(1)) >> FRAC_BITS);
        r1 = '0;
        g1 = '0;
        b1 = '0;
        case (sector)
            SECT_RED_YEL:
            begin
                r1 = chroma;
                g1 = second;
            end
            SECT_YEL_GRN:
            begin
                r1 = second;
                g1 = chroma;
            end
            SECT_GRN_CYN:
            begin
                g1 = chroma;
                b1 = second;
            end
            SECT_CYN_BLU:
            begin
                g1 = second;
                b1 = chroma;
            end
            SECT_BLU_MAG:
            begin
                r1 = second;
                b1 = chroma;
            end
            default:
            begin
                r1 = chroma;
                b1 = second;
            end
        endcase

        offset    = bri - chroma;
        res.red   = r1 + offset;
        res.green = g1 + offset;
        res.blue  = b1 + offset;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [CHAN_W-1:0] exp_v,
                                   input logic [CHAN_W-1:0] got_v);
        fail_total++;
        if (fail_total <= MAX_PRINTS)
            $display("mismatch: result beat %0d %s expected %0d got %0d",
                     beat_count, what, exp_v, got_v);
    endtask

    task automatic check_result();
        rgba_t exp_px;

        if (expected_rgba.size() == 0)
        begin
            fail_total++;
            if (fail_total <= MAX_PRINTS)
                $display("mismatch: result beat %0d arrived with nothing pending",
                         beat_count);
            return;
        end
        exp_px = expected_rgba.pop_front();
        if (red !== exp_px.red)
            report_mismatch("red", exp_px.red, red);
        if (green !== exp_px.green)
            report_mismatch("green", exp_px.green, green);
        if (blue !== exp_px.blue)
            report_mismatch("blue", exp_px.blue, blue);
        if (alpha !== exp_px.alpha)
            report_mismatch("alpha", exp_px.alpha, alpha);
    endtask

    initial
    begin
        fail_total = 0;
        beat_count = 0;
        mode_copy  = MODE_RGB;
        pending    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_rgba.delete();
            mode_copy = MODE_RGB;
            pending   <= 0;
        end
        else
        begin
            if (result_valid === 1'b1 && result_stall === 1'b0)
            begin
                check_result();
                beat_count++;
            end
            if (item_valid === 1'b1 && item_stall === 1'b0)
                expected_rgba = {expected_rgba, predict_rgba(mode_copy, chan_a, chan_b,
                                                             chan_c, chan_d)};
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                mode_copy = cfg_data;
            pending <= expected_rgba.size();
        end
    end

endmodule

@@ verif/tb_hsb_to_rgb_converter_unit.sv @@
// ----------------------------------------------------------------------------
// tb_hsb_to_rgb_converter_unit
// Drives mode writes and pixel beats into the converter with random idle gaps
// on the input, except in steady phases, and random stalls on the result, in
// phases separated by drained pauses. Checking is done by pixel_result_check.
// ----------------------------------------------------------------------------
module tb_hsb_to_rgb_converter_unit;
    import hsbrgb_pkg::*;

    localparam int LATENCY      = 3;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 8;
    localparam int PHASE_PIXELS = 160;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_data;
    logic              item_valid;
    logic              item_stall;
    logic [CHAN_W-1:0] chan_a;
    logic [CHAN_W-1:0] chan_b;
    logic [CHAN_W-1:0] chan_c;
    logic [CHAN_W-1:0] chan_d;
    logic              result_valid;
    logic              result_stall;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;

    int   error_count;
    int   pending;
    int   cycle_count;
    logic steady_input;

    hsb_to_rgb_converter_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .chan_a       (chan_a),
        .chan_b       (chan_b),
        .chan_c       (chan_c),
        .chan_d       (chan_d),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha)
    );

    pixel_result_check u_check
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .chan_a       (chan_a),
        .chan_b       (chan_b),
        .chan_c       (chan_c),
        .chan_d       (chan_d),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .alpha        (alpha),
        .error_count  (error_count),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;

        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 40);
    endfunction

    // Result stalls come in runs: long quiet runs, short stalls, rare long stalls.
    initial
    begin
        int hold;
        int r;

        hold = 0;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    result_stall <= 1'b0;
                    hold = $urandom_range(1, 60);
                end
                else if (r < 92)
                begin
                    result_stall <= 1'b1;
                    hold = $urandom_range(0, 3);
                end
                else
                begin
                    result_stall <= 1'b1;
                    hold = $urandom_range(5, 40);
                end
            end
        end
    end

    function automatic logic [CHAN_W-1:0] rand_chan();
        int r;

        r = $urandom_range(0, 9);
        if (r < 6)
            return CHAN_W'($urandom_range(0, ONE));
        if (r < 8)
            return CHAN_W'($urandom_range(0, (1 << CHAN_W) - 1));
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CHAN_W'(1);
            2: return ONE - CHAN_W'(1);
            3: return ONE;
            4: return ONE + CHAN_W'(1);
            default: return '1;
        endcase
    endfunction

    // Hue values are often placed right on or next to a sector boundary.
    function automatic logic [CHAN_W-1:0] rand_hue();
        int k;

        if ($urandom_range(0, 3) != 0)
            return rand_chan();
        k = ($urandom_range(0, 6) * ONE) / 6;
        k = k + $urandom_range(0, 2) - 1;
        if (k < 0)
            k = 0;
        return CHAN_W'(k);
    endfunction

    task automatic drive_pixel(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b,
                               input logic [CHAN_W-1:0] c, input logic [CHAN_W-1:0] d);
        int gap;

        gap = steady_input ? 0 : pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        chan_a     <= a;
        chan_b     <= b;
        chan_c     <= c;
        chan_d     <= d;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
    endtask

    // Hold the input off until every predicted pixel has come out.
    task automatic wait_drained();
        item_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_mode(input logic mode);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic mode;

        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 1'b0;
        item_valid   = 1'b0;
        chan_a       = '0;
        chan_b       = '0;
        chan_c       = '0;
        chan_d       = '0;
        steady_input = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pass-through: extremes and out of range channels.
        write_mode(MODE_RGB);
        drive_pixel('0, '0, '0, '0);
        drive_pixel(ONE, ONE, ONE, ONE);
        drive_pixel('1, '1, '1, '1);
        drive_pixel(13'h1555, 13'h0AAA, 13'h1555, 13'h0AAA);
        drive_pixel(ONE + 13'd1, 13'd1, ONE - 13'd1, '1);
        wait_drained();

        // Conversion: every sector with its boundaries, saturation of
        // channels above one, zero saturation and zero brightness.
        write_mode(MODE_HSB);
        drive_pixel(13'd0, ONE, ONE, 13'd0);
        drive_pixel(13'd682, ONE, ONE, ONE);
        drive_pixel(13'd683, ONE, ONE, 13'd77);
        drive_pixel(13'd1365, 13'd3000, ONE, '1);
        drive_pixel(13'd1366, 13'd3000, 13'd3500, 13'd5);
        drive_pixel(13'd2048, ONE, ONE, 13'd9);
        drive_pixel(13'd2730, 13'd2000, 13'd4000, 13'd100);
        drive_pixel(13'd2731, 13'd2000, 13'd4000, 13'd200);
        drive_pixel(13'd3413, ONE, 13'd2500, 13'd300);
        drive_pixel(13'd3414, ONE, 13'd2500, 13'd400);
        drive_pixel(ONE, ONE, ONE, ONE);
        drive_pixel('1, '1, '1, '1);
        drive_pixel(13'd5000, 13'd2048, 13'd6000, 13'd123);
        drive_pixel(13'd1000, 13'd0, 13'd3000, 13'd4097);
        drive_pixel(13'd1000, ONE, 13'd0, 13'd1);
        drive_pixel(ONE - 13'd1, ONE - 13'd1, ONE - 13'd1, ONE - 13'd1);
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            mode = (phase % 3 == 1) ? MODE_RGB : MODE_HSB;
            write_mode(mode);
            steady_input = (phase % 4 == 3);
            for (int i = 0; i < PHASE_PIXELS; i++)
                drive_pixel(mode == MODE_HSB ? rand_hue() : rand_chan(),
                            rand_chan(), rand_chan(), rand_chan());
            wait_drained();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
